// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the calibrator RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define GZOC_ASSERT_SAME(name, a, b) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("same-cycle implication failed");
// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define GZOC_ASSERT_NEXT(name, a, b) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");
`else
`define GZOC_ASSERT_SAME(name, a, b)
`define GZOC_ASSERT_NEXT(name, a, b)
`endif
`endif

// File: hw/rtl/gzoc_pkg.sv
// Types and constants of the gyro zero-offset calibrator.
package gzoc_pkg;

	localparam int OP_W      = 2;
	localparam int TIME_W    = 32;
	localparam int ANGLE_W   = 16;
	localparam int CODE_W    = 12;
	localparam int CORR_W    = 12;
	localparam int STAGE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int COUNT_W   = 16;
	localparam int MAXDEV_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_STEP   = 2'd0,
		OP_TARGET = 2'd1,
		OP_INIT   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STAGE_W-1:0] {
		ST_GRAB  = 2'd0,
		ST_CHECK = 2'd1,
		ST_ACCUM = 2'd2,
		ST_WAIT  = 2'd3
	} stage_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_COUNT = 2'd0,
		CFG_REPEAT_MS    = 2'd1,
		CFG_MAX_DEV      = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST = 16'd1000;
	localparam logic [TIME_W-1:0]   REPEAT_MS_RST    = 32'd5000;
	localparam logic [MAXDEV_W-1:0] MAX_DEV_RST      = 16'd16;

	localparam logic [CORR_W-1:0] MID_CODE        = 12'h7FF;
	localparam logic [TIME_W-1:0] CHECK_PERIOD_MS = 32'd500;
	localparam logic [1:0]        CHECKS_NEEDED   = 2'd3;

	typedef struct packed {
		logic step;
		logic div_start;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_needed;
		logic div_done;
	} dp_status_t;

endpackage

// File: hw/rtl/gzoc_if.sv
// Handshake channels for sample items and result items.
interface gzoc_in_if;
	import gzoc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [TIME_W-1:0]    time_ms;
	logic [ANGLE_W-1:0]   shaft_angle;
	logic [CODE_W-1:0]    rate_code;
	logic [ANGLE_W-1:0]   target_angle;

	modport source (output valid, operation, time_ms, shaft_angle, rate_code,
		target_angle, input ready);
	modport sink (input valid, operation, time_ms, shaft_angle, rate_code,
		target_angle, output ready);
endinterface

interface gzoc_out_if;
	import gzoc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      correction_ready;
	logic signed [CORR_W-1:0]  correction;
	logic [STAGE_W-1:0]        stage;

	modport source (output valid, correction_ready, correction, stage, input ready);
	modport sink (input valid, correction_ready, correction, stage, output ready);
endinterface

// File: hw/rtl/gzoc_div.sv
// Restoring divider, one quotient bit per cycle.
module gzoc_div #(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		fits    = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder always stays below the divisor, so it fits DIVISOR_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: hw/rtl/gzoc_ctrl.sv
// Controller: sequences item acceptance, the division and the output register.
module gzoc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  gzoc_pkg::dp_status_t   status,
	output gzoc_pkg::ctrl_cmd_t    cmd
);
	import gzoc_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_DIV_GO,
		C_DIV_WAIT,
		C_HOLD
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        out_valid_q;
	logic        out_free;

	always_comb begin
		out_free      = !out_valid_q || out_ready;
		in_ready      = state_q == C_IDLE;
		cmd.step      = (state_q == C_IDLE) && in_valid;
		cmd.div_start = state_q == C_DIV_GO;
		cmd.load_out  = (state_q == C_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (in_valid)
						state_q <= status.div_needed ? C_DIV_GO : C_HOLD;
				end
				C_DIV_GO: begin
					state_q <= C_DIV_WAIT;
				end
				C_DIV_WAIT: begin
					if (status.div_done)
						state_q <= C_HOLD;
				end
				C_HOLD: begin
					if (out_free)
						state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: hw/rtl/gzoc_dp.sv
// Datapath: configuration, sequencer state, angle check, code sum and divider.
module gzoc_dp #(
	parameter int ANGLE_BITS = 16,
	parameter int CODE_BITS  = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gzoc_pkg::ctrl_cmd_t               cmd,
	output gzoc_pkg::dp_status_t              status,
	input  logic                              cfg_we,
	input  logic [gzoc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gzoc_pkg::CFG_W-1:0]        cfg_data,
	input  logic [gzoc_pkg::OP_W-1:0]         operation,
	input  logic [gzoc_pkg::TIME_W-1:0]       time_ms,
	input  logic [gzoc_pkg::ANGLE_W-1:0]      shaft_angle,
	input  logic [gzoc_pkg::CODE_W-1:0]       rate_code,
	input  logic [gzoc_pkg::ANGLE_W-1:0]      target_angle,
	output logic                              correction_ready,
	output logic signed [gzoc_pkg::CORR_W-1:0] correction,
	output logic [gzoc_pkg::STAGE_W-1:0]      stage
);
	import gzoc_pkg::*;

	localparam int SUM_W = CODE_BITS + COUNT_BITS;
	localparam int DEV_W = (ANGLE_BITS > MAXDEV_W) ? ANGLE_BITS : MAXDEV_W;
	localparam logic [ANGLE_BITS-1:0] HALF_CIRCLE = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	// Configuration registers.
	logic [COUNT_W-1:0]  sample_count_q;
	logic [TIME_W-1:0]   repeat_ms_q;
	logic [MAXDEV_W-1:0] max_dev_q;

	// Sequencer state.
	stage_t                 stage_q;
	logic [ANGLE_BITS-1:0]  ref_angle_q;
	logic [1:0]             steady_q;
	logic [TIME_W-1:0]      phase_start_q;
	logic [COUNT_BITS-1:0]  samples_q;
	logic [SUM_W-1:0]       sum_q;
	logic [ANGLE_W-1:0]     cal_target_q;
	logic [CORR_W-1:0]      last_corr_q;
	logic                   res_ready_q;

	// Output register.
	logic                   out_ready_flag_q;
	logic [CORR_W-1:0]      out_corr_q;
	stage_t                 out_stage_q;

	op_t                    op;
	stage_t                 eff_stage;
	logic                   target_hit;
	logic                   is_step_op;
	logic [TIME_W-1:0]      elapsed;
	logic [ANGLE_BITS-1:0]  angle_m;
	logic [CODE_BITS-1:0]   code_m;
	logic [ANGLE_BITS-1:0]  diff;
	logic [ANGLE_BITS-1:0]  arc;
	logic                   in_limit;
	logic [COUNT_BITS-1:0]  count;
	logic [COUNT_BITS:0]    divisor;
	logic [COUNT_BITS-1:0]  samples_nx;
	logic [SUM_W-1:0]       sum_nx;
	logic [1:0]             steady_nx;
	logic                   div_done;
	logic [SUM_W-1:0]       quotient;

	always_comb begin
		op         = op_t'(operation);
		is_step_op = (op == OP_STEP) || (op == OP_TARGET);
		target_hit = (op == OP_TARGET) && (target_angle != cal_target_q);
		eff_stage  = target_hit ? ST_GRAB : stage_q;
		elapsed    = time_ms - phase_start_q;
		angle_m    = ANGLE_BITS'(shaft_angle);
		code_m     = CODE_BITS'(rate_code);
		// Shorter way round the circle; exactly half a circle stays as it is.
		diff       = angle_m - ref_angle_q;
		arc        = (diff > HALF_CIRCLE) ? (ANGLE_BITS'(0) - diff) : diff;
		in_limit   = DEV_W'(arc) <= DEV_W'(max_dev_q);
		count      = COUNT_BITS'(sample_count_q);
		divisor    = {count == '0, count};
		samples_nx = samples_q + 1'b1;
		sum_nx     = sum_q + SUM_W'(code_m);
		steady_nx  = steady_q + 2'd1;
		status.div_needed = is_step_op && (eff_stage == ST_ACCUM) && in_limit
			&& (samples_nx == count);
		status.div_done   = div_done;
	end

	gzoc_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (COUNT_BITS + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			repeat_ms_q    <= REPEAT_MS_RST;
			max_dev_q      <= MAX_DEV_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_W-1:0];
				CFG_REPEAT_MS:    repeat_ms_q    <= cfg_data[TIME_W-1:0];
				CFG_MAX_DEV:      max_dev_q      <= cfg_data[MAXDEV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= ST_WAIT;
			ref_angle_q   <= '0;
			steady_q      <= '0;
			phase_start_q <= '0;
			samples_q     <= '0;
			sum_q         <= '0;
			cal_target_q  <= '0;
			last_corr_q   <= '0;
			res_ready_q   <= 1'b0;
		end else begin
			if (div_done)
				last_corr_q <= MID_CODE - quotient[CORR_W-1:0];
			if (cmd.step) begin
				res_ready_q <= status.div_needed;
				unique case (op)
					OP_INIT: begin
						stage_q       <= ST_WAIT;
						phase_start_q <= time_ms;
						samples_q     <= '0;
						sum_q         <= '0;
					end
					OP_STEP, OP_TARGET: begin
						if (target_hit)
							cal_target_q <= target_angle;
						stage_q <= eff_stage;
						unique case (eff_stage)
							ST_GRAB: begin
								ref_angle_q   <= angle_m;
								steady_q      <= '0;
								phase_start_q <= time_ms;
								stage_q       <= ST_CHECK;
							end
							ST_CHECK: begin
								if (elapsed >= CHECK_PERIOD_MS) begin
									if (in_limit) begin
										phase_start_q <= time_ms;
										steady_q      <= steady_nx;
										if (steady_nx == CHECKS_NEEDED) begin
											samples_q <= '0;
											sum_q     <= '0;
											stage_q   <= ST_ACCUM;
										end
									end else begin
										stage_q <= ST_GRAB;
									end
								end
							end
							ST_ACCUM: begin
								if (!in_limit) begin
									stage_q <= ST_GRAB;
								end else begin
									sum_q     <= sum_nx;
									samples_q <= samples_nx;
									if (samples_nx == count) begin
										stage_q       <= ST_WAIT;
										phase_start_q <= time_ms;
									end
								end
							end
							default: begin
								if (elapsed >= repeat_ms_q)
									stage_q <= ST_GRAB;
							end
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ready_flag_q <= res_ready_q;
			out_corr_q       <= last_corr_q;
			out_stage_q      <= stage_q;
		end
	end

	assign correction_ready = out_ready_flag_q;
	assign correction       = out_corr_q;
	assign stage            = out_stage_q;
endmodule

// File: hw/rtl/gyro_zero_offset_calibrator_top.sv
// Top level of the gyro zero-offset calibrator.
//
//  Channel     Direction  Handshake           Payload
//  sample_in   in         valid/ready         operation, time_ms, shaft_angle,
//                                             rate_code, target_angle
//  result_out  out        valid/ready         correction_ready, correction, stage
//  cfg         in         cfg_we (no wait)    cfg_index, cfg_data
//
// An item that does not finish a calibration goes from acceptance to the hold state, which
// loads it into the output register once that register is free; the next item can then be taken.
// One that finishes a calibration first passes through the divider start and wait states,
// held there by the restoring divider, one quotient bit a cycle, until the quotient is done.
// Reset is asynchronous and needs no clearing pass.
// One result may wait in the output register while the next item is accepted and worked
// on; that item's result then holds until the output register is taken.
module gyro_zero_offset_calibrator_top #(
	parameter int ANGLE_BITS = 16,
	parameter int CODE_BITS  = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gzoc_in_if.sink                        sample_in,
	gzoc_out_if.source                     result_out,
	input  logic                           cfg_we,
	input  logic [gzoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gzoc_pkg::CFG_W-1:0]     cfg_data
);
	import gzoc_pkg::*;
	`include "assert_macros.svh"

	ctrl_cmd_t  cmd;
	dp_status_t status;

	gzoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gzoc_dp #(
		.ANGLE_BITS (ANGLE_BITS),
		.CODE_BITS  (CODE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (sample_in.operation),
		.time_ms          (sample_in.time_ms),
		.shaft_angle      (sample_in.shaft_angle),
		.rate_code        (sample_in.rate_code),
		.target_angle     (sample_in.target_angle),
		.correction_ready (result_out.correction_ready),
		.correction       (result_out.correction),
		.stage            (result_out.stage)
	);

	// A completing item must go on to start the divider in the following cycle.
	`GZOC_ASSERT_NEXT(a_div_follows, cmd.step && status.div_needed, cmd.div_start)
	// No item is taken while a division is under way.
	`GZOC_ASSERT_NEXT(a_busy_in_div, cmd.div_start, !sample_in.ready)
	// Loading the output register always presents a result next cycle.
	`GZOC_ASSERT_NEXT(a_load_shows, cmd.load_out, result_out.valid)
	// A fresh correction is only ever reported together with the wait stage.
	`GZOC_ASSERT_SAME(a_ready_in_wait, result_out.valid && result_out.correction_ready,
		result_out.stage == ST_WAIT)
endmodule
